[rtl/ggn_pkg.sv]
package ggn_pkg;

    // Coordinate width and the deepest subdivision level the grid supports.
    localparam int CW        = 12;
    localparam int MAX_LEVEL = 12;
    localparam int LW        = 4;
    localparam int IW        = 28;

    // Grid numbers with a special meaning.
    localparam logic [3:0] SQ_POLE      = 4'd10;
    localparam logic [3:0] SQ_LAST      = 4'd9;
    localparam logic [3:0] SQ_LAST_EVEN = 4'd8;

    // Direction codes.
    localparam logic [2:0] DIR_UP         = 3'd0;
    localparam logic [2:0] DIR_RIGHT      = 3'd1;
    localparam logic [2:0] DIR_DOWN       = 3'd2;
    localparam logic [2:0] DIR_LEFT       = 3'd3;
    localparam logic [2:0] DIR_UP_LEFT    = 3'd4;
    localparam logic [2:0] DIR_DOWN_RIGHT = 3'd5;

    // Input word.
    typedef struct packed {
        logic [3:0]    square_index;
        logic [CW-1:0] cell_row;
        logic [CW-1:0] cell_column;
        logic [2:0]    direction;
        logic          incoming_duplicate;
    } t_in;

    // Result word.
    typedef struct packed {
        logic [3:0]    next_square;
        logic [CW-1:0] next_row;
        logic [CW-1:0] next_column;
        logic          corner_duplicate;
        logic [IW-1:0] point_index;
        logic          bad_direction;
    } t_out;

    // One cell of the grid with its duplicate flag.
    typedef struct packed {
        logic [3:0]    sq;
        logic [CW-1:0] row;
        logic [CW-1:0] col;
        logic          dup;
    } t_cell;

    // Work carried down the pipeline: the cell, the steps still to take, and
    // the invalid-direction flag.
    typedef struct packed {
        t_cell      loc;
        logic [2:0] dir_a;
        logic [2:0] dir_b;
        logic [1:0] steps;
        logic       bad;
    } t_work;

endpackage

[rtl/ggn_step.sv]
module ggn_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  ggn_pkg::t_work            i_work,
    input  logic [ggn_pkg::CW-1:0]    i_edge_max,
    output logic                      o_valid,
    input  logic                      i_ready,
    output ggn_pkg::t_work            o_work
);
    import ggn_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;

    // One plain step on the grid, including the moves out of a pole cell.
    function automatic t_cell f_step(t_cell c, logic [2:0] d, logic [CW-1:0] b);
        t_cell n;
        logic  odd;
        n   = c;
        odd = c.sq[0];
        if (c.sq >= SQ_POLE) begin
            if (c.col == '0) begin
                n.col = b;
                n.row = '0;
                n.sq  = (d == DIR_DOWN_RIGHT) ? 4'd0 : {d, 1'b0};
            end else begin
                n.col = '0;
                n.row = b;
                n.sq  = (d == DIR_DOWN_RIGHT) ? 4'd1 : {d, 1'b1};
            end
            if (d == DIR_DOWN_RIGHT) begin
                n.dup = 1'b1;
            end
        end else begin
            case (d)
                DIR_UP: begin
                    if (c.row != '0) begin
                        n.row = c.row - 1'b1;
                    end else if (odd) begin
                        n.sq  = c.sq - 4'd1;
                        n.row = b;
                    end else begin
                        n.sq = (c.sq == 4'd0) ? SQ_LAST_EVEN : c.sq - 4'd2;
                        if (c.col == '0) begin
                            n.dup = 1'b1;
                            n.sq  = (n.sq == 4'd0) ? SQ_LAST : n.sq - 4'd1;
                        end else begin
                            n.row = b - c.col + 1'b1;
                        end
                        n.col = b;
                    end
                end
                DIR_RIGHT: begin
                    if (c.col != b) begin
                        n.col = c.col + 1'b1;
                    end else if (odd) begin
                        n.sq  = (c.sq == SQ_LAST) ? 4'd0 : c.sq + 4'd1;
                        n.col = '0;
                    end else if (c.row == '0) begin
                        n.sq  = SQ_POLE;
                        n.row = '0;
                        n.col = '0;
                    end else begin
                        n.sq  = (c.sq == SQ_LAST_EVEN) ? 4'd0 : c.sq + 4'd2;
                        n.row = '0;
                        n.col = b - c.row + 1'b1;
                    end
                end
                DIR_DOWN: begin
                    if (c.row != b) begin
                        n.row = c.row + 1'b1;
                    end else if (odd) begin
                        if (c.col == '0) begin
                            n.sq  = SQ_POLE;
                            n.row = '0;
                            n.col = {{(CW-1){1'b0}}, 1'b1};
                        end else begin
                            n.sq  = (c.sq == SQ_LAST) ? 4'd1 : c.sq + 4'd2;
                            n.col = '0;
                            n.row = b + 1'b1 - c.col;
                        end
                    end else begin
                        n.sq  = c.sq + 4'd1;
                        n.row = '0;
                    end
                end
                default: begin
                    // Left; the diagonal codes never reach a single plain step.
                    if (c.col != '0) begin
                        n.col = c.col - 1'b1;
                    end else if (odd) begin
                        if (c.row == '0) begin
                            n.dup = 1'b1;
                            n.sq  = c.sq - 4'd1;
                        end else begin
                            n.sq  = (c.sq == 4'd1) ? SQ_LAST : c.sq - 4'd2;
                            n.col = b + 1'b1 - c.row;
                        end
                        n.row = b;
                    end else begin
                        n.sq  = (c.sq == 4'd0) ? SQ_LAST : c.sq - 4'd1;
                        n.col = b;
                    end
                end
            endcase
        end
        return n;
    endfunction

    // Take the next pending step, if any, and shift the second direction up.
    always_comb begin
        n_work = i_work;
        if (i_work.steps != 2'd0) begin
            n_work.loc   = f_step(i_work.loc, i_work.dir_a, i_edge_max);
            n_work.dir_a = i_work.dir_b;
            n_work.steps = i_work.steps - 2'd1;
        end
    end

    // Stage register; it fills whenever it is empty or its word moves on.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

[rtl/ggn_index.sv]
module ggn_index (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  ggn_pkg::t_work            i_work,
    input  logic [ggn_pkg::LW-1:0]    i_level,
    output logic                      o_valid,
    input  logic                      i_ready,
    output ggn_pkg::t_out             o_data
);
    import ggn_pkg::*;

    logic          r_valid;
    t_out          r_data;
    t_out          n_data;
    logic [IW-1:0] sq_part;
    logic [IW-1:0] row_part;
    logic [IW-1:0] col_part;

    // Flat index: grid times 4^level plus row times 2^level plus column.
    always_comb begin
        if (i_work.loc.sq >= SQ_POLE) begin
            sq_part  = {{(IW-4){1'b0}}, SQ_POLE} << {i_level, 1'b0};
            row_part = '0;
            col_part = {{(IW-1){1'b0}}, (i_work.loc.col != '0)};
        end else begin
            sq_part  = {{(IW-4){1'b0}}, i_work.loc.sq} << {i_level, 1'b0};
            row_part = {{(IW-CW){1'b0}}, i_work.loc.row} << i_level;
            col_part = {{(IW-CW){1'b0}}, i_work.loc.col};
        end
    end

    // Result word; an invalid direction clears every field but its flag.
    always_comb begin
        if (i_work.bad) begin
            n_data               = '0;
            n_data.bad_direction = 1'b1;
        end else begin
            n_data.next_square      = i_work.loc.sq;
            n_data.next_row         = i_work.loc.row;
            n_data.next_column      = i_work.loc.col;
            n_data.corner_duplicate = i_work.loc.dup;
            n_data.point_index      = sq_part + row_part + col_part;
            n_data.bad_direction    = 1'b0;
        end
    end

    // Output register.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/geodesic_grid_neighbor.sv]
// Channel   Direction  Handshake                   Word
// in        input      i_in_valid / o_in_ready     i_in_data  (t_in)
// out       output     o_out_valid / i_out_ready   o_out_data (t_out)
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_data (grid_generation)
//
// Four register stages: input and step planning, first plain step, second
// plain step, point index and output register. A new word is taken every
// cycle unless the output stalls. Each stage holds its word until the next
// one can take it, so an output stall fills bubbles first and then pushes
// back to the input. Reset clears all valid bits and sets the level to zero.
module geodesic_grid_neighbor (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  ggn_pkg::t_in            i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output ggn_pkg::t_out           o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [ggn_pkg::LW-1:0]  i_cfg_data
);
    import ggn_pkg::*;

    logic [LW-1:0] r_level;
    logic [CW-1:0] edge_max;
    logic [CW-1:0] row_m;
    logic [CW-1:0] col_m;
    logic          odd;
    logic          r_valid;
    t_work         r_work;
    t_work         n_work;
    logic          a_valid;
    logic          a_ready;
    t_work         a_work;
    logic          b_valid;
    logic          b_ready;
    t_work         b_work;
    logic          x_ready;

    // Level register, clamped to the deepest supported level on write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cfg_valid) begin
            r_level <= (i_cfg_data > LW'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : i_cfg_data;
        end
    end

    // Largest row or column at the current level.
    assign edge_max = ~({CW{1'b1}} << r_level);

    // Mask the coordinates and plan up to two plain steps.
    assign row_m = i_in_data.cell_row & edge_max;
    assign col_m = i_in_data.cell_column & edge_max;
    assign odd   = i_in_data.square_index[0];

    always_comb begin
        n_work          = '0;
        n_work.loc.sq   = i_in_data.square_index;
        n_work.loc.row  = row_m;
        n_work.loc.col  = col_m;
        n_work.loc.dup  = i_in_data.incoming_duplicate;
        n_work.dir_a    = i_in_data.direction;
        n_work.dir_b    = DIR_UP;
        n_work.steps    = 2'd1;
        n_work.bad      = (i_in_data.direction > DIR_DOWN_RIGHT);
        if (n_work.bad) begin
            n_work.steps = 2'd0;
        end else if (i_in_data.square_index >= SQ_POLE) begin
            n_work.loc.sq  = SQ_POLE;
            n_work.loc.row = '0;
            n_work.loc.col = {{(CW-1){1'b0}}, (i_in_data.cell_column != '0)};
        end else if (i_in_data.direction == DIR_UP_LEFT) begin
            n_work.steps = 2'd2;
            if (odd) begin
                n_work.dir_b = DIR_LEFT;
                n_work.dir_a = (col_m == '0 && row_m != '0) ? DIR_LEFT : DIR_UP;
            end else begin
                n_work.dir_b = DIR_UP;
                n_work.dir_a = (row_m == '0 && col_m != '0) ? DIR_UP : DIR_LEFT;
            end
        end else if (i_in_data.direction == DIR_DOWN_RIGHT) begin
            n_work.steps = 2'd2;
            n_work.dir_a = odd ? DIR_RIGHT : DIR_DOWN;
            n_work.dir_b = odd ? DIR_DOWN : DIR_RIGHT;
        end
    end

    // Input stage register.
    assign o_in_ready = !r_valid || a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_work <= n_work;
        end
    end

    // Two plain step stages.
    ggn_step u_step_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_valid),
        .o_ready    (a_ready),
        .i_work     (r_work),
        .i_edge_max (edge_max),
        .o_valid    (a_valid),
        .i_ready    (b_ready),
        .o_work     (a_work)
    );

    ggn_step u_step_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (a_valid),
        .o_ready    (b_ready),
        .i_work     (a_work),
        .i_edge_max (edge_max),
        .o_valid    (b_valid),
        .i_ready    (x_ready),
        .o_work     (b_work)
    );

    // Point index and output register.
    ggn_index u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid),
        .o_ready (x_ready),
        .i_work  (b_work),
        .i_level (r_level),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // Every planned step has been taken by the time a word leaves the steps.
    a_steps_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_valid |-> b_work.steps == 2'd0)
        else $error("word left the step stages with steps pending");

    // An invalid direction yields an all-zero result apart from its flag.
    a_bad_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bad_direction) |->
        (o_out_data.next_square == 4'd0 && o_out_data.point_index == '0 &&
         o_out_data.corner_duplicate == 1'b0))
        else $error("invalid direction result carries data");

    // A pole result sits on row zero and column zero or one.
    a_pole_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.bad_direction &&
         o_out_data.next_square == SQ_POLE) |->
        (o_out_data.next_row == '0 && o_out_data.next_column[CW-1:1] == '0))
        else $error("malformed pole result");

    // Results name a real grid or the pole grid.
    a_square_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.next_square <= SQ_POLE)
        else $error("result grid number out of range");

endmodule
